@@ sv/rre_pkg.sv @@
// package for the rolling resistance estimator
// states, register indexes, fixed-point constants and the cordic arctangent table
`default_nettype none
package rre_pkg;

  localparam int CordicSteps = 16;
  localparam int AtanEntries = 24;
  localparam int CordicIter = (CordicSteps < AtanEntries) ? CordicSteps : AtanEntries;

  localparam logic [33:0] CordicK = 34'd652032874;
  localparam logic [19:0] GravQ16 = 20'd642908;
  localparam logic signed [19:0] DegToRad = 20'sd187404;

  localparam logic [2:0] RegMass   = 3'd0;
  localparam logic [2:0] RegRadius = 3'd1;
  localparam logic [2:0] RegPeriod = 3'd2;
  localparam logic [2:0] RegGain   = 3'd3;
  localparam logic [2:0] RegGear   = 3'd4;
  localparam logic [2:0] RegFloor  = 3'd5;

  typedef enum logic [3:0] {
    StIdle,
    StAccDiv,
    StFiltMul,
    StMrMul,
    StTgMul,
    StDrvDiv,
    StCordic,
    StSinMul,
    StCosMul,
    StCrDiv,
    StResult
  } state_e;

  function automatic logic [33:0] atan_q30(input logic [4:0] idx);
    logic [33:0] v;
    case (idx)
      5'd0:  v = 34'd843314856;
      5'd1:  v = 34'd497837829;
      5'd2:  v = 34'd263043836;
      5'd3:  v = 34'd133525158;
      5'd4:  v = 34'd67021686;
      5'd5:  v = 34'd33543515;
      5'd6:  v = 34'd16775850;
      5'd7:  v = 34'd8388437;
      5'd8:  v = 34'd4194282;
      5'd9:  v = 34'd2097149;
      5'd10: v = 34'd1048575;
      5'd11: v = 34'd524287;
      5'd12: v = 34'd262143;
      5'd13: v = 34'd131071;
      5'd14: v = 34'd65535;
      5'd15: v = 34'd32767;
      5'd16: v = 34'd16383;
      5'd17: v = 34'd8191;
      5'd18: v = 34'd4095;
      5'd19: v = 34'd2047;
      5'd20: v = 34'd1023;
      5'd21: v = 34'd511;
      5'd22: v = 34'd255;
      5'd23: v = 34'd127;
      default: v = 34'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ sv/rre_mul.sv @@
// bit-serial unsigned multiplier, one multiplier bit per cycle
// no dependencies
`default_nettype none
module rre_mul (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [33:0] a_i,
  input  wire logic [19:0] b_i,
  output logic             done_o,
  output logic [53:0]      prod_o
);

  logic [33:0] a_q;
  logic [54:0] acc_q, acc_d;
  logic [35:0] sum;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;

  always_comb begin
    sum   = {1'b0, acc_q[54:20]} + (acc_q[0] ? {2'b0, a_q} : 36'd0);
    acc_d = {sum, acc_q[19:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd19;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      acc_q <= {35'd0, b_i};
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q[53:0];

endmodule
`default_nettype wire

@@ sv/rre_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
// no dependencies
`default_nettype none
module rre_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  input  wire logic [31:0] den_i,
  output logic             done_o,
  output logic [63:0]      quo_o
);

  logic [63:0] n_q;
  logic [31:0] d_q, rem_q;
  logic [32:0] sh;
  logic        ge;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;

  always_comb begin
    sh = {rem_q, n_q[63]};
    ge = (sh >= {1'b0, d_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd63;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      d_q   <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? 32'(sh - {1'b0, d_q}) : sh[31:0];
      n_q   <= {n_q[62:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = n_q;

endmodule
`default_nettype wire

@@ sv/rolling_resistance_estimator.sv @@
// rolling resistance estimator, top level: sequencer, cordic, state and registers
// uses rre_pkg, rre_mul and rre_div
// each word runs three serial divides, five serial multiplies and a cordic in turn;
// a floored result skips the last divide
// one word in flight; the next is taken only once the last is through, and later
// while a finished word still waits in the output register
// reset: registers take their documented defaults, speed and filter state clear
`default_nettype none
module rolling_resistance_estimator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] speed_i,
  input  wire logic [15:0] motor_torque_i,
  input  wire logic [13:0] pitch_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      coefficient_o,
  output logic             floored_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  rre_pkg::state_e state_q, state_d;

  // configuration registers
  logic [11:0] mass_q;
  logic [15:0] radius_q, period_q, gain_q, gear_q, floor_q;

  // persistent state
  logic [15:0] prev_q;
  logic [31:0] filt_q;

  // captured sample and intermediate values
  logic [15:0] spd_q, trq_q;
  logic [13:0] pitch_q;
  logic [31:0] accel_q;
  logic [27:0] mr_q;
  logic [31:0] tg_q;
  logic [48:0] drive_q;
  logic [49:0] num_q;
  logic [24:0] den_q;
  logic [15:0] res_coef_q;
  logic        res_fl_q;
  logic        launch_q;

  // cordic datapath
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic [4:0]         ccnt_q;

  // shared serial units
  logic        mul_start, mul_done, div_start, div_done;
  logic [33:0] mul_a;
  logic [19:0] mul_b;
  logic [53:0] mul_p;
  logic [63:0] div_n, div_q;
  logic [31:0] div_d;

  logic        in_acc, out_acc;
  logic        cordic_end;

  // acceleration operands
  logic signed [16:0] sdiff;
  logic               sneg;
  logic [15:0]        smag;
  // filter operands
  logic signed [32:0] af;
  logic               afneg;
  logic [32:0]        afmag;
  logic               tneg;
  logic [15:0]        tmag;
  logic [54:0]        sprod;
  logic               pneg;
  logic [31:0]        filt_next;
  logic [31:0]        accel_next;
  logic [24:0]        gterm;
  logic [49:0]        num_next;
  logic [15:0]        per_eff;

  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == rre_pkg::StIdle);
  assign cordic_end  = !launch_q && (ccnt_q == 5'(rre_pkg::CordicIter));

  always_comb begin
    sdiff = $signed({1'b0, spd_q}) - $signed({1'b0, prev_q});
    sneg  = sdiff[16];
    smag  = sneg ? 16'(-sdiff) : sdiff[15:0];
    af    = $signed({accel_q[31], accel_q}) - $signed({filt_q[31], filt_q});
    afneg = af[32];
    afmag = afneg ? 33'(-af) : 33'(af);
    tneg  = trq_q[15];
    tmag  = tneg ? 16'(-$signed(trq_q)) : trq_q;
    per_eff = (period_q == 16'd0) ? 16'd1 : period_q;
  end

  // sign of the current product
  always_comb begin
    case (state_q)
      rre_pkg::StFiltMul: pneg = afneg;
      rre_pkg::StSinMul:  pneg = cy_q[33];
      rre_pkg::StCosMul:  pneg = cx_q[33];
      default:            pneg = 1'b0;
    endcase
    sprod = pneg ? 55'(-{1'b0, mul_p}) : {1'b0, mul_p};
    gterm = sprod[54:30];
  end

  always_comb begin
    // filter: f + floor(gain*(a - f) / 2^16)
    filt_next = filt_q + sprod[47:16];
    // acceleration magnitude quotient back to a saturated signed value
    if (!sneg) begin
      accel_next = (div_q[63:31] != 33'd0) ? 32'h7fff_ffff : div_q[31:0];
    end else begin
      accel_next = ((div_q[63:32] != 32'd0) || (div_q[31] && div_q[30:0] != 31'd0))
                   ? 32'h8000_0000 : 32'(-div_q[31:0]);
    end
    num_next = $signed(drive_q) - $signed({{18{filt_q[31]}}, filt_q})
             - $signed({{25{gterm[24]}}, gterm});
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rre_pkg::StIdle:    if (in_acc) state_d = rre_pkg::StAccDiv;
      rre_pkg::StAccDiv:  if (div_done) state_d = rre_pkg::StFiltMul;
      rre_pkg::StFiltMul: if (mul_done) state_d = rre_pkg::StMrMul;
      rre_pkg::StMrMul:   if (mul_done) state_d = rre_pkg::StTgMul;
      rre_pkg::StTgMul:   if (mul_done) state_d = rre_pkg::StDrvDiv;
      rre_pkg::StDrvDiv:  if (div_done) state_d = rre_pkg::StCordic;
      rre_pkg::StCordic:  if (cordic_end) state_d = rre_pkg::StSinMul;
      rre_pkg::StSinMul:  if (mul_done) state_d = rre_pkg::StCosMul;
      rre_pkg::StCosMul: begin
        if (mul_done) state_d = num_q[49] ? rre_pkg::StResult : rre_pkg::StCrDiv;
      end
      rre_pkg::StCrDiv:   if (div_done) state_d = rre_pkg::StResult;
      rre_pkg::StResult:  if (!out_valid_o || out_ready_i) state_d = rre_pkg::StIdle;
      default:            state_d = rre_pkg::StIdle;
    endcase
  end

  // unit launches and operand selection
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_n     = '0;
    div_d     = 32'd1;
    case (state_q)
      rre_pkg::StAccDiv: begin
        div_start = launch_q;
        div_n     = {24'd0, smag, 24'd0};
        div_d     = {16'd0, per_eff};
      end
      rre_pkg::StFiltMul: begin
        mul_start = launch_q;
        mul_a     = {1'b0, afmag};
        mul_b     = {4'd0, gain_q};
      end
      rre_pkg::StMrMul: begin
        mul_start = launch_q;
        mul_a     = {22'd0, mass_q};
        mul_b     = {4'd0, radius_q};
      end
      rre_pkg::StTgMul: begin
        mul_start = launch_q;
        mul_a     = {18'd0, tmag};
        mul_b     = {4'd0, gear_q};
      end
      rre_pkg::StDrvDiv: begin
        div_start = launch_q;
        div_n     = {16'd0, tg_q, 16'd0};
        div_d     = {4'd0, mr_q};
      end
      rre_pkg::StSinMul: begin
        mul_start = launch_q;
        mul_a     = cy_q[33] ? 34'(-cy_q) : cy_q;
        mul_b     = rre_pkg::GravQ16;
      end
      rre_pkg::StCosMul: begin
        mul_start = launch_q;
        mul_a     = cx_q[33] ? 34'(-cx_q) : cx_q;
        mul_b     = rre_pkg::GravQ16;
      end
      rre_pkg::StCrDiv: begin
        div_start = launch_q;
        div_n     = {2'd0, num_q, 12'd0};
        div_d     = {7'd0, den_q};
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  rre_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  rre_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_n),
    .den_i   (div_d),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  // control, configuration and persistent state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rre_pkg::StIdle;
      launch_q    <= 1'b0;
      out_valid_o <= 1'b0;
      mass_q      <= 12'd700;
      radius_q    <= 16'd15729;
      period_q    <= 16'd6554;
      gain_q      <= 16'd13107;
      gear_q      <= 16'd16847;
      floor_q     <= 16'd410;
      prev_q      <= '0;
      filt_q      <= '0;
    end else begin
      state_q  <= state_d;
      launch_q <= (state_d != state_q);
      if (cfg_valid_i) begin
        case (cfg_index_i)
          rre_pkg::RegMass:   mass_q   <= cfg_data_i[11:0];
          rre_pkg::RegRadius: radius_q <= cfg_data_i;
          rre_pkg::RegPeriod: period_q <= cfg_data_i;
          rre_pkg::RegGain:   gain_q   <= cfg_data_i;
          rre_pkg::RegGear:   gear_q   <= cfg_data_i;
          rre_pkg::RegFloor:  floor_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == rre_pkg::StFiltMul && mul_done) filt_q <= filt_next;
      if (state_q == rre_pkg::StResult && state_d == rre_pkg::StIdle) begin
        out_valid_o <= 1'b1;
        prev_q      <= spd_q;
      end else if (out_acc) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // datapath words
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      spd_q   <= speed_i;
      trq_q   <= motor_torque_i;
      pitch_q <= pitch_i;
    end
    case (state_q)
      rre_pkg::StAccDiv: if (div_done) accel_q <= accel_next;
      rre_pkg::StMrMul: begin
        if (mul_done) mr_q <= (mul_p[27:0] == 28'd0) ? 28'd1 : mul_p[27:0];
      end
      rre_pkg::StTgMul: if (mul_done) tg_q <= mul_p[31:0];
      rre_pkg::StDrvDiv: begin
        if (div_done) drive_q <= tneg ? 49'(-{1'b0, div_q[47:0]}) : {1'b0, div_q[47:0]};
      end
      rre_pkg::StCordic: begin
        // one micro-rotation per cycle
        if (launch_q) begin
          cx_q   <= rre_pkg::CordicK;
          cy_q   <= '0;
          cz_q   <= 34'($signed(pitch_q) * rre_pkg::DegToRad);
          ccnt_q <= '0;
        end else if (!cordic_end) begin
          if (!cz_q[33]) begin
            cx_q <= cx_q - (cy_q >>> ccnt_q);
            cy_q <= cy_q + (cx_q >>> ccnt_q);
            cz_q <= cz_q - $signed(rre_pkg::atan_q30(ccnt_q));
          end else begin
            cx_q <= cx_q + (cy_q >>> ccnt_q);
            cy_q <= cy_q - (cx_q >>> ccnt_q);
            cz_q <= cz_q + $signed(rre_pkg::atan_q30(ccnt_q));
          end
          ccnt_q <= ccnt_q + 5'd1;
        end
      end
      rre_pkg::StSinMul: if (mul_done) num_q <= num_next;
      rre_pkg::StCosMul: begin
        if (mul_done) begin
          // non-positive cosine term is taken as one
          den_q      <= ($signed(gterm) <= 0) ? 25'd1 : gterm;
          res_coef_q <= floor_q;
          res_fl_q   <= 1'b1;
        end
      end
      rre_pkg::StCrDiv: begin
        if (div_done) begin
          res_coef_q <= (div_q[63:16] != 48'd0) ? 16'hffff : div_q[15:0];
          res_fl_q   <= 1'b0;
        end
      end
      rre_pkg::StResult: begin
        if (!out_valid_o || out_ready_i) begin
          coefficient_o <= res_coef_q;
          floored_o     <= res_fl_q;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ verif/tb_rolling_resistance_estimator.sv @@
// testbench for the rolling resistance estimator: directed and random samples,
// register settings and idle phases, every result checked against a local predictor
// depends on rre_pkg (register indexes, cordic step count) and the rtl top level
`default_nettype none
module tb_rolling_resistance_estimator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit  = 40000;  // cycles without any handshake
  localparam int SettleWait = 400;    // beyond the latency of one word

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [15:0] speed_i;
  logic [15:0] motor_torque_i;
  logic [13:0] pitch_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] coefficient_o;
  logic        floored_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  rolling_resistance_estimator DUT (.*);

  typedef struct packed {
    logic [15:0] coefficient;
    logic        floored;
  } cr_word_t;

  cr_word_t expected_cr[$];
  int       error_count = 0;
  int       sender_idle_pct = 0;
  int       receiver_stall_pct = 0;

  // shadow of the registers and of the running state
  logic [11:0] mass_reg;
  logic [15:0] radius_reg, period_reg, gain_reg, gear_reg, floor_reg;
  logic [15:0] last_speed;
  longint      accel_lp;

  // arctangent table, q30, truncated
  longint atan_tab [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // works out the coefficient word for one sample and advances the state
  function automatic cr_word_t predict_coefficient(input logic [15:0] spd,
                                                   input logic signed [15:0] trq,
                                                   input logic signed [13:0] pch);
    longint period, mr, accel, drive, x, y, z, dx, dy, num, den, q;
    cr_word_t w;
    period = (period_reg == 0) ? 1 : longint'(period_reg);
    accel = (longint'(spd) - longint'(last_speed)) * (longint'(1) << 24) / period;
    if (accel > 64'sd2147483647) accel = 64'sd2147483647;
    if (accel < -64'sd2147483648) accel = -64'sd2147483648;
    // first-order low-pass, floor on the shift
    accel_lp = (longint'(gain_reg) * accel + (65536 - longint'(gain_reg)) * accel_lp) >>> 16;
    mr = longint'(mass_reg) * longint'(radius_reg);
    if (mr == 0) mr = 1;
    drive = longint'(trq) * longint'(gear_reg) * 65536 / mr;
    // rotation-mode cordic from the pitch angle in q30 radians
    z = longint'(pch) * 187404;
    x = 652032874;
    y = 0;
    for (int i = 0; i < rre_pkg::CordicIter; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    num = drive - accel_lp - ((longint'(642908) * y) >>> 30);
    den = (longint'(642908) * x) >>> 30;
    if (den <= 0) den = 1;
    if (num < 0) begin
      // negative estimate takes the floor value
      w.coefficient = floor_reg;
      w.floored = 1'b1;
    end else begin
      q = num * 4096 / den;
      if (q > 65535) q = 65535;
      w.coefficient = q[15:0];
      w.floored = 1'b0;
    end
    last_speed = spd;
    return w;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  // sends one sample word; called at a clock edge, returns at its acceptance edge
  task automatic send_sample(input logic [15:0] spd, input logic [15:0] trq,
                             input logic [13:0] pch);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    speed_i        <= spd;
    motor_torque_i <= trq;
    pitch_i        <= pch;
    do @(posedge clk_i); while (!in_ready_o);
    expected_cr.push_back(predict_coefficient(spd, trq, pch));
  endtask

  // lowers valid, waits for every outstanding word and lets the block settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_cr.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      rre_pkg::RegMass:   mass_reg   = data[11:0];
      rre_pkg::RegRadius: radius_reg = data;
      rre_pkg::RegPeriod: period_reg = data;
      rre_pkg::RegGain:   gain_reg   = data;
      rre_pkg::RegGear:   gear_reg   = data;
      rre_pkg::RegFloor:  floor_reg  = data;
      default: ;  // unmapped index, ignored
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_all(input logic [15:0] m, input logic [15:0] r, input logic [15:0] p,
                           input logic [15:0] g, input logic [15:0] gr, input logic [15:0] f);
    write_reg(rre_pkg::RegMass, m);
    write_reg(rre_pkg::RegRadius, r);
    write_reg(rre_pkg::RegPeriod, p);
    write_reg(rre_pkg::RegGain, g);
    write_reg(rre_pkg::RegGear, gr);
    write_reg(rre_pkg::RegFloor, f);
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk_i) begin
    cr_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_cr.size() == 0) begin
        $display("unexpected coefficient word %0d at %0t", coefficient_o, $realtime);
        error_count++;
      end else begin
        want = expected_cr.pop_front();
        if (coefficient_o !== want.coefficient)
          report_mismatch("coefficient", int'(coefficient_o), int'(want.coefficient));
        if (floored_o !== want.floored)
          report_mismatch("floored", int'(floored_o), int'(want.floored));
      end
    end
    out_ready_i <= rst_ni && ($urandom_range(99) >= receiver_stall_pct);
  end

  // watchdog on handshake activity
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // defaults after reset: zero, extremes of every field, a floored estimate
  task automatic test_reset_values();
    send_sample(16'd0, 16'd0, 14'd0);
    send_sample(16'd2560, 16'sd800, 14'd0);
    send_sample(16'd2600, 16'sd800, 14'sd300);
    send_sample(16'hFFFF, 16'h7FFF, 14'sd4500);     // large speed step up, accel stays below saturation
    send_sample(16'd0, 16'h8000, -14'sd4500);       // hard braking, negative torque
    send_sample(16'd0, 16'h8000, 14'h1FFF);         // pitch beyond range, top
    send_sample(16'd1000, 16'h7FFF, 14'h2000);      // pitch beyond range, bottom
    send_sample(16'd1000, 16'h0000, 14'sd4500);     // uphill with no drive, floored
  endtask

  // zero divisor registers, filter gain extremes, unmapped indexes
  task automatic test_register_extremes();
    drain_results();
    write_reg(3'd6, 16'h1234);
    write_reg(3'd7, 16'hFFFF);
    write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(16'd500, 16'sd100, 14'sd100);
    send_sample(16'd0, 16'h8000, 14'sd0);
    drain_results();
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(16'hFFFF, 16'h7FFF, -14'sd4500);
    send_sample(16'h0000, 16'h8000, 14'sd4500);
    send_sample(16'h8000, 16'h7FFF, 14'sd0);
    drain_results();
    write_all(16'd1, 16'd1, 16'd1, 16'd65535, 16'hFFFF, 16'd0);
    send_sample(16'd1, 16'h7FFF, 14'sd0);           // tiny period, huge drive
    send_sample(16'd0, 16'h8000, 14'sd0);
    drain_results();
    write_all(16'd700, 16'd15729, 16'd6554, 16'd13107, 16'd16847, 16'd410);
    send_sample(16'd2560, 16'sd1600, -14'sd200);
  endtask

  // mostly smooth drive cycles, some jumps and out-of-range pitch
  task automatic test_random_phase(input int n_items, input int s_idle, input int r_stall);
    logic [15:0] spd, trq;
    logic [13:0] pch;
    drain_results();
    if ($urandom_range(1))
      write_all(16'($urandom_range(4095, 1)), 16'($urandom_range(65535, 1)),
                16'($urandom_range(65535, 1)), 16'($urandom_range(65535)),
                16'($urandom_range(65535, 1)), 16'($urandom_range(65535)));
    else
      write_all(16'($urandom_range(1500, 600)), 16'($urandom_range(25000, 10000)),
                16'($urandom_range(8000, 3000)), 16'($urandom_range(40000, 5000)),
                16'($urandom_range(30000, 8000)), 16'($urandom_range(1000)));
    sender_idle_pct = s_idle;
    receiver_stall_pct = r_stall;
    spd = 16'($urandom_range(8000));
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(9) == 0) spd = 16'($urandom);
      else spd = 16'(spd + $urandom_range(200) - 100);
      trq = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1600) - 400);
      pch = ($urandom_range(7) == 0) ? 14'($urandom) : 14'($urandom_range(9000) - 4500);
      send_sample(spd, trq, pch);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    speed_i = '0;
    motor_torque_i = '0;
    pitch_i = '0;
    mass_reg = 12'd700;
    radius_reg = 16'd15729;
    period_reg = 16'd6554;
    gain_reg = 16'd13107;
    gear_reg = 16'd16847;
    floor_reg = 16'd410;
    last_speed = '0;
    accel_lp = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_register_extremes();
    test_random_phase(355, 0, 0);
    test_random_phase(355, 75, 0);
    test_random_phase(355, 0, 75);
    test_random_phase(355, 26, 26);
    drain_results();

    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
